// ----- hdl/svm_pkg.sv -----
// Shared types and constants of the stack machine execute unit.
// No dependencies; compiled first.
package svm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_BITS   = 16;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 8;
    localparam int IP_OUT_W = 16;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    // stack pointer holds 0..STACK_DEPTH; stack RAM is indexed below that
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int MEM_AW = $clog2(STACK_DEPTH);

    localparam logic [OP_W-1:0] OP_ADD   = OP_W'(0);
    localparam logic [OP_W-1:0] OP_SUB   = OP_W'(1);
    localparam logic [OP_W-1:0] OP_CONST = OP_W'(2);
    localparam logic [OP_W-1:0] OP_BRT   = OP_W'(3);
    localparam logic [OP_W-1:0] OP_HALT  = OP_W'(4);

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN   = 2'd0,
        ST_HALT  = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    typedef struct packed {
        logic [IP_OUT_W-1:0]      next_ip;
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
        t_status                  status;
    } t_result;

endpackage

// ----- hdl/svm_if.sv -----
// Valid/ready channel interfaces for instruction words and step results.
// Depends on svm_pkg.
interface svm_in_if import svm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     func;
    logic [WORD_W-1:0]   immediate;

    modport source (output valid, output func, output immediate, input ready);
    modport sink   (input valid, input func, input immediate, output ready);
endinterface

interface svm_out_if import svm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IP_OUT_W-1:0]      next_ip;
    logic signed [WORD_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output next_ip, output top_value, output stack_depth,
                    output status, input ready);
    modport sink   (input valid, input next_ip, input top_value, input stack_depth,
                    input status, output ready);
endinterface

// ----- hdl/svm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/stack_vm_execute_step_unit.sv -----
// Stack machine execute unit: one instruction word in, one step result out.
// Depends on svm_pkg, svm_if (svm_in_if, svm_out_if) and svm_ram.

// The unit executes one instruction per clock cycle while ready is high, and
// registers its result when the word is accepted. The top two stack words live
// in registers; the rest of the stack sits in a RAM with one write and one
// registered read port, which is always pointed at the word that the next pop
// brings up, so each step needs only that single read. A result register plus
// one skid entry let a new word be taken while a result waits; ready drops only
// when both are full or reset is asserted. After a halt or a stack fault the
// unit keeps accepting words and repeats the stopped state until reset.
module stack_vm_execute_step_unit import svm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svm_in_if.sink     i_in,
    svm_out_if.source  o_out
);

    logic [ADDR_BITS-1:0] r_ip, n_ip;
    logic [SP_W-1:0]      r_sp, n_sp;
    logic [WORD_W-1:0]    r_tos, n_tos;
    logic [WORD_W-1:0]    r_nos, n_nos;
    logic                 r_stopped, n_stopped;
    t_status              r_held_status, n_held_status;
    logic [WORD_W-1:0]    r_held_value, n_held_value;

    logic                 r_fwd_vld;
    logic [WORD_W-1:0]    r_fwd_data;
    logic [WORD_W-1:0]    mem_q;
    logic [WORD_W-1:0]    mem_top;
    logic                 mem_we;
    logic [SP_W-1:0]      sp_m2;
    logic [SP_W-1:0]      rd_sp;
    logic [SP_W-1:0]      rd_m3;
    logic [MEM_AW-1:0]    mem_waddr;
    logic [MEM_AW-1:0]    mem_raddr;

    logic                 accept;
    logic                 out_fire;
    logic [WORD_W-1:0]    cur_top;
    t_result              res;
    t_result              r_out, r_skid;
    logic                 r_out_vld, r_skid_vld;

    assign accept   = i_in.valid && i_in.ready;
    assign out_fire = r_out_vld && o_out.ready;
    // hold off words while in reset; they would be dropped
    assign i_in.ready = i_rst_n && !r_skid_vld;

    // third word from the top; a just-written word is taken from the bypass
    assign mem_top = r_fwd_vld ? r_fwd_data : mem_q;
    assign cur_top = (r_sp == '0) ? '0 : r_tos;

    always_comb begin
        n_ip          = r_ip;
        n_sp          = r_sp;
        n_tos         = r_tos;
        n_nos         = r_nos;
        n_stopped     = r_stopped;
        n_held_status = r_held_status;
        n_held_value  = r_held_value;
        mem_we        = 1'b0;
        if (!r_stopped) begin
            unique case (i_in.func)
                OP_ADD, OP_SUB: begin
                    if (r_sp < SP_W'(2)) begin
                        n_stopped     = 1'b1;
                        n_held_status = ST_UNDER;
                        n_held_value  = cur_top;
                    end else begin
                        n_tos = (i_in.func == OP_ADD) ? r_nos + r_tos : r_nos - r_tos;
                        n_nos = mem_top;
                        n_sp  = r_sp - SP_W'(1);
                        n_ip  = r_ip + ADDR_BITS'(1);
                    end
                end
                OP_CONST: begin
                    if (r_sp >= SP_W'(STACK_DEPTH)) begin
                        n_stopped     = 1'b1;
                        n_held_status = ST_OVER;
                        n_held_value  = cur_top;
                    end else begin
                        // spill the second word to the RAM when it is occupied
                        n_tos  = i_in.immediate;
                        n_nos  = r_tos;
                        mem_we = (r_sp >= SP_W'(2));
                        n_sp   = r_sp + SP_W'(1);
                        n_ip   = r_ip + ADDR_BITS'(5);
                    end
                end
                OP_BRT: begin
                    if (r_sp == '0) begin
                        n_stopped     = 1'b1;
                        n_held_status = ST_UNDER;
                        n_held_value  = '0;
                    end else if (r_tos != '0) begin
                        n_ip = ADDR_BITS'(i_in.immediate);
                    end else begin
                        n_ip = r_ip + ADDR_BITS'(5);
                    end
                end
                OP_HALT: begin
                    if (r_sp == '0) begin
                        n_stopped     = 1'b1;
                        n_held_status = ST_UNDER;
                        n_held_value  = '0;
                    end else begin
                        n_tos         = r_nos;
                        n_nos         = mem_top;
                        n_sp          = r_sp - SP_W'(1);
                        n_stopped     = 1'b1;
                        n_held_status = ST_HALT;
                        n_held_value  = r_tos;
                    end
                end
                default: begin
                    n_ip = r_ip + ADDR_BITS'(1);
                end
            endcase
        end
    end

    always_comb begin
        res.next_ip     = IP_OUT_W'(n_ip);
        res.stack_depth = DEPTH_W'(n_sp);
        if (n_stopped) begin
            res.status    = n_held_status;
            res.top_value = n_held_value;
        end else begin
            res.status    = ST_RUN;
            res.top_value = (n_sp == '0) ? '0 : n_tos;
        end
    end

    // RAM holds words 0..sp-3; keep its read port on the topmost of them
    assign sp_m2     = r_sp - SP_W'(2);
    assign mem_waddr = sp_m2[MEM_AW-1:0];
    assign rd_sp     = accept ? n_sp : r_sp;
    assign rd_m3     = rd_sp - SP_W'(3);
    assign mem_raddr = rd_m3[MEM_AW-1:0];

    svm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (accept && mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_nos),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip          <= '0;
            r_sp          <= '0;
            r_stopped     <= 1'b0;
            r_held_status <= ST_RUN;
            r_held_value  <= '0;
            r_fwd_vld     <= 1'b0;
        end else begin
            // a push writes exactly the address read next, so bypass it
            r_fwd_vld <= accept && mem_we;
            if (accept) begin
                r_ip          <= n_ip;
                r_sp          <= n_sp;
                r_stopped     <= n_stopped;
                r_held_status <= n_held_status;
                r_held_value  <= n_held_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= r_nos;
        if (accept) begin
            r_tos <= n_tos;
            r_nos <= n_nos;
        end
    end

    // result register with one skid word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (accept) begin
            if (!r_out_vld || out_fire) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (out_fire) begin
            if (r_skid_vld) begin
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_vld || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (out_fire && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.next_ip     = r_out.next_ip;
    assign o_out.top_value   = r_out.top_value;
    assign o_out.stack_depth = r_out.stack_depth;
    assign o_out.status      = r_out.status;

    a_sp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held without a result in front");

    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_stopped) |=> ($stable(r_ip) && $stable(r_sp) && r_stopped))
        else $error("stopped machine changed state");

    a_bypass_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && mem_we) |-> (mem_raddr == mem_waddr))
        else $error("push does not refill the RAM read port");

endmodule
